// ===== rtl/sparse_vector_byte_decoder_unit_assert.svh =====
// assertion macros for the sparse vector byte decoder
`ifndef SPARSE_VECTOR_BYTE_DECODER_UNIT_ASSERT_SVH
`define SPARSE_VECTOR_BYTE_DECODER_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define SVBD_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// condition implies consequence in the following cycle
`define SVBD_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/svbd_pkg.sv =====
// shared constants and types of the sparse vector byte decoder
package svbd_pkg;

  // internal position counter width and width of the reported position
  localparam int POS_BITS     = 20;
  localparam int POS_OUT_BITS = 20;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;

  // result kinds
  localparam kind_t KIND_ELEM = 2'd0;
  localparam kind_t KIND_RUN  = 2'd1;
  localparam kind_t KIND_END  = 2'd2;

  // result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_WIDE     = 2'd1;
  localparam status_t ST_OPEN_ESC = 2'd2;
  localparam status_t ST_POS_OVF  = 2'd3;

  // code byte classes, upper nibble or upper bits
  localparam logic [3:0] NIB_RUN_SHORT = 4'hC;
  localparam logic [3:0] NIB_RUN_LONG  = 4'hD;
  localparam logic [1:0] TOP_LITERAL   = 2'b00;
  localparam logic [1:0] TOP_PACK2     = 2'b01;
  localparam logic [1:0] TOP_PACK3     = 2'b10;
  localparam logic [2:0] TOP_ESCAPE    = 3'b111;

endpackage

// ===== rtl/svbd_if.sv =====
// handshake channels for code bytes and decoded results

interface svbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;

  modport source (output valid, output code_byte, output last_byte, input ready);
  modport sink   (input valid, input code_byte, input last_byte, output ready);
endinterface

interface svbd_result_if;
  logic                                valid;
  logic                                ready;
  svbd_pkg::kind_t                     kind;
  logic [svbd_pkg::POS_OUT_BITS-1:0]   position;
  logic [15:0]                         value;
  logic [8:0]                          run_length;
  svbd_pkg::status_t                   status;
  logic                                last_result;

  modport source (output valid, output kind, output position, output value,
                  output run_length, output status, output last_result, input ready);
  modport sink   (input valid, input kind, input position, input value,
                  input run_length, input status, input last_result, output ready);
endinterface

// ===== rtl/sparse_vector_byte_decoder_unit.sv =====
// top level of the sparse vector byte decoder
//
// Usage: code bytes enter on in_ch (code_byte, last_byte), one transfer per
// byte. Decoded items leave on out_ch: element, zero-run and end-of-vector
// items, each with its position, value, run length and status; last_result
// marks the final item caused by one byte.
// A byte sits in a hold register and its items are produced one per cycle
// into an output register while out_ch does not stall; its first item
// passes through the hold register and then the output register. A byte
// that yields one item (or none) frees the hold register in the cycle it is
// decoded, so such bytes stream at one per cycle when out_ch does not stall;
// a byte with k items stays held until the single output register has
// taken all k (at most four: three packed elements plus the end item).
// Escape continuation bytes that leave the escape open produce no data item.
// Reset (rst, synchronous) empties both registers and clears position, the
// escape accumulator and the overflow flag. The same state is cleared after
// the end item of every vector.
// When out_ch stalls, the output register holds its item, the hold register
// keeps its byte, and in_ch ready drops until the item is taken.
module sparse_vector_byte_decoder_unit (
  input  logic                clk,
  input  logic                rst,
  svbd_byte_if.sink           in_ch,
  svbd_result_if.source       out_ch
);
  import svbd_pkg::*;

  // decoder state
  logic [POS_BITS-1:0] next_pos;
  logic                pos_ovf;
  logic [15:0]         acc_low;
  logic                acc_wide;
  logic                in_esc;

  // hold register
  logic                hold_valid;
  logic [7:0]          hold_byte;
  logic                hold_last;
  logic [1:0]          idx;

  // output register
  logic                out_valid;
  kind_t               out_kind;
  logic [POS_OUT_BITS-1:0] out_pos;
  logic [15:0]         out_value;
  logic [8:0]          out_run;
  status_t             out_status;
  logic                out_last;

  // decode of the held byte
  logic [7:0]          b;
  logic                is_run_s, is_run_l, is_lit, is_pack2, is_pack3, is_open;
  logic [22:0]         esc_full;
  logic                esc_wide;
  logic                esc_close;
  logic [1:0]          n_data;
  logic [2:0]          n_total;
  logic                cur_is_end;
  logic                cur_is_run;
  logic [15:0]         cur_value;
  logic                cur_wide;
  logic [8:0]          adv_n;
  logic                new_esc;

  // position advance
  logic [POS_BITS-1:0] pos_rem;
  logic [POS_BITS+8:0] rem_x, adv_x;
  logic                sat;
  logic [POS_BITS-1:0] pos_after;
  logic [POS_BITS+POS_OUT_BITS-1:0] pos_ext;

  // handshake
  logic                out_free;
  logic                fire;
  logic                done;
  logic                in_take;

  // byte classes
  always_comb begin
    b        = hold_byte;
    is_run_s = (b[7:4] == NIB_RUN_SHORT);
    is_run_l = (b[7:4] == NIB_RUN_LONG);
    is_lit   = (b[7:6] == TOP_LITERAL);
    is_pack2 = (b[7:6] == TOP_PACK2);
    is_pack3 = (b[7:6] == TOP_PACK3);
    is_open  = (b[7:5] == TOP_ESCAPE);
    esc_full  = {acc_low, b[6:0]};
    esc_wide  = acc_wide | (|esc_full[22:16]);
    esc_close = b[7];
  end

  // item counts and escape state after this byte
  always_comb begin
    if (in_esc) begin
      n_data  = esc_close ? 2'd1 : 2'd0;
      new_esc = ~esc_close;
    end else begin
      new_esc = is_open;
      if (is_pack3)                          n_data = 2'd3;
      else if (is_pack2)                     n_data = 2'd2;
      else if (is_lit || is_run_s || is_run_l) n_data = 2'd1;
      else                                   n_data = 2'd0;
    end
    n_total    = {1'b0, n_data} + {2'b00, hold_last};
    cur_is_end = ({1'b0, idx} >= {1'b0, n_data});
  end

  // fields of the current data item
  always_comb begin
    cur_is_run = 1'b0;
    cur_value  = 16'd0;
    cur_wide   = 1'b0;
    adv_n      = 9'd1;
    if (in_esc) begin
      cur_value = esc_full[15:0];
      cur_wide  = esc_wide;
    end else if (is_run_s) begin
      cur_is_run = 1'b1;
      adv_n      = {5'd0, b[3:0]} + 9'd1;
    end else if (is_run_l) begin
      cur_is_run = 1'b1;
      adv_n      = {({1'b0, b[3:0]} + 5'd1), 4'b0000};
    end else if (is_lit) begin
      cur_value = {8'd0, b};
    end else if (is_pack2) begin
      case (idx)
        2'd0:    cur_value = {13'd0, b[5:3]};
        default: cur_value = {13'd0, b[2:0]};
      endcase
    end else begin
      case (idx)
        2'd0:    cur_value = {14'd0, b[5:4]};
        2'd1:    cur_value = {14'd0, b[3:2]};
        default: cur_value = {14'd0, b[1:0]};
      endcase
    end
  end

  // saturating position advance
  always_comb begin
    pos_rem   = POS_MAX - next_pos;
    rem_x     = {9'd0, pos_rem};
    adv_x     = {{POS_BITS{1'b0}}, adv_n};
    sat       = (adv_x > rem_x);
    pos_after = sat ? POS_MAX : (next_pos + POS_BITS'(adv_n));
    pos_ext   = {{POS_OUT_BITS{1'b0}}, next_pos};
  end

  // handshake control
  always_comb begin
    out_free = ~out_valid | out_ch.ready;
    fire     = hold_valid & (n_total != 3'd0) & out_free;
    done     = hold_valid & ((n_total == 3'd0) ||
                             (fire && ({1'b0, idx} == n_total - 3'd1)));
    in_take  = in_ch.valid & in_ch.ready;
  end

  assign in_ch.ready = ~hold_valid | done;

  // hold register and item index
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (in_take) begin
        hold_valid <= 1'b1;
        idx        <= 2'd0;
      end else if (done) begin
        hold_valid <= 1'b0;
        idx        <= 2'd0;
      end else if (fire) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_byte <= in_ch.code_byte;
      hold_last <= in_ch.last_byte;
    end
  end

  // decoder state update
  always_ff @(posedge clk) begin
    if (rst) begin
      next_pos <= '0;
      pos_ovf  <= 1'b0;
      acc_low  <= 16'd0;
      acc_wide <= 1'b0;
      in_esc   <= 1'b0;
    end else begin
      if (fire && !cur_is_end) begin
        next_pos <= pos_after;
        pos_ovf  <= pos_ovf | sat;
      end
      if (done) begin
        if (hold_last) begin
          next_pos <= '0;
          pos_ovf  <= 1'b0;
          acc_low  <= 16'd0;
          acc_wide <= 1'b0;
          in_esc   <= 1'b0;
        end else if (in_esc) begin
          in_esc <= ~esc_close;
          if (esc_close) begin
            acc_low  <= 16'd0;
            acc_wide <= 1'b0;
          end else begin
            acc_low  <= esc_full[15:0];
            acc_wide <= esc_wide;
          end
        end else if (is_open) begin
          in_esc   <= 1'b1;
          acc_low  <= {11'd0, b[4:0]};
          acc_wide <= 1'b0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pos  <= pos_ext[POS_OUT_BITS-1:0];
      out_last <= ({1'b0, idx} == n_total - 3'd1);
      if (cur_is_end) begin
        out_kind   <= KIND_END;
        out_value  <= 16'd0;
        out_run    <= 9'd0;
        out_status <= new_esc ? ST_OPEN_ESC : (pos_ovf ? ST_POS_OVF : ST_OK);
      end else if (cur_is_run) begin
        out_kind   <= KIND_RUN;
        out_value  <= 16'd0;
        out_run    <= adv_n;
        out_status <= (pos_ovf | sat) ? ST_POS_OVF : ST_OK;
      end else begin
        out_kind   <= KIND_ELEM;
        out_value  <= cur_value;
        out_run    <= 9'd0;
        out_status <= (pos_ovf | sat) ? ST_POS_OVF : (cur_wide ? ST_WIDE : ST_OK);
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.kind        = out_kind;
  assign out_ch.position    = out_pos;
  assign out_ch.value       = out_value;
  assign out_ch.run_length  = out_run;
  assign out_ch.status      = out_status;
  assign out_ch.last_result = out_last;

  // checks
`include "sparse_vector_byte_decoder_unit_assert.svh"

  `SVBD_ASSERT_NOW(a_silent_byte_frees, clk, rst, hold_valid && (n_total == 3'd0),
    in_ch.ready, "byte without items did not free the hold register")
  `SVBD_ASSERT_NOW(a_end_is_last, clk, rst, out_valid && (out_kind == KIND_END),
    out_last, "end item not marked as last result")
  `SVBD_ASSERT_NOW(a_ovf_saturated, clk, rst, pos_ovf,
    next_pos == POS_MAX, "overflow flag set but position not saturated")
  `SVBD_ASSERT_NEXT(a_end_clears, clk, rst, fire && cur_is_end && done,
    (next_pos == '0) && !in_esc && !pos_ovf, "state not cleared after end item")

endmodule
